// ----- hdl/afl_pkg.sv -----
// Shared types and constants for the aspect fit/fill layout core.
// No dependencies; compiled first.
package afl_pkg;

	localparam int DIM_W     = 16;
	localparam int POS_W     = DIM_W + 1;
	localparam int PROD_W    = 2 * DIM_W;
	localparam int DIV_STEPS = DIM_W;
	localparam int CFG_IDX_W = 3;

	typedef logic [DIM_W-1:0]        dim_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [PROD_W-1:0]       prod_t;

	typedef enum logic [2:0] {
		SM_FIT       = 3'd0,
		SM_FILL      = 3'd1,
		SM_FILL_W    = 3'd2,
		SM_FILL_H    = 3'd3,
		SM_STRETCH   = 3'd4,
		SM_STRETCH_X = 3'd5,
		SM_STRETCH_Y = 3'd6,
		SM_NONE      = 3'd7
	} scale_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_MODE  = 3'd0,
		REG_ALIGN_MODE  = 3'd1,
		REG_TARGET_W    = 3'd2,
		REG_TARGET_H    = 3'd3,
		REG_CONTAINER_W = 3'd4,
		REG_CONTAINER_H = 3'd5
	} cfg_idx_t;

	// anchor placement along one axis
	typedef enum logic [1:0] {
		PL_START  = 2'd0,
		PL_CENTER = 2'd1,
		PL_END    = 2'd2,
		PL_NONE   = 2'd3
	} place_t;

	// which output dimension comes from the quotient
	typedef enum logic [1:0] {
		QS_NONE = 2'd0,
		QS_W    = 2'd1,
		QS_H    = 2'd2
	} qsel_t;

	typedef struct packed {
		logic  bad;
		qsel_t qsel;
		dim_t  w_fix;
		dim_t  h_fix;
	} ctl_t;

	typedef struct packed {
		ctl_t ctl;
		logic sat;
		dim_t den;
		dim_t rem;
		dim_t lo;
		dim_t q;
	} div_t;

	localparam dim_t RST_TARGET_W    = 16'd2048;
	localparam dim_t RST_TARGET_H    = 16'd512;
	localparam dim_t RST_CONTAINER_W = 16'd2048;
	localparam dim_t RST_CONTAINER_H = 16'd512;
	localparam logic [3:0] RST_ALIGN = 4'd4;

	function automatic place_t align_col(logic [3:0] a);
		place_t p;
		unique case (a)
			4'd0, 4'd3, 4'd6: p = PL_START;
			4'd1, 4'd4, 4'd7: p = PL_CENTER;
			4'd2, 4'd5, 4'd8: p = PL_END;
			default:          p = PL_NONE;
		endcase
		return p;
	endfunction

	function automatic place_t align_row(logic [3:0] a);
		place_t p;
		unique case (a)
			4'd0, 4'd1, 4'd2: p = PL_START;
			4'd3, 4'd4, 4'd5: p = PL_CENTER;
			4'd6, 4'd7, 4'd8: p = PL_END;
			default:          p = PL_NONE;
		endcase
		return p;
	endfunction

endpackage

// ----- hdl/afl_req_if.sv -----
// Request channel: source size, valid/ready handshake.
// Depends on afl_pkg.
interface afl_req_if;
	logic          valid;
	logic          ready;
	afl_pkg::dim_t source_w;
	afl_pkg::dim_t source_h;

	modport source (output valid, output source_w, output source_h, input ready);
	modport sink (input valid, input source_w, input source_h, output ready);
endinterface

// ----- hdl/afl_rsp_if.sv -----
// Result channel: scaled size, aligned position and bad-source flag.
// Depends on afl_pkg.
interface afl_rsp_if;
	logic          valid;
	logic          ready;
	afl_pkg::dim_t out_w;
	afl_pkg::dim_t out_h;
	afl_pkg::pos_t pos_x;
	afl_pkg::pos_t pos_y;
	logic          bad_source;

	modport source (output valid, output out_w, output out_h, output pos_x,
		output pos_y, output bad_source, input ready);
	modport sink (input valid, input out_w, input out_h, input pos_x,
		input pos_y, input bad_source, output ready);
endinterface

// ----- hdl/afl_cfg_if.sv -----
// Configuration write channel: register index and data, valid/ready.
// Depends on afl_pkg.
interface afl_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [afl_pkg::CFG_IDX_W-1:0]     index;
	logic [afl_pkg::DIM_W-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/aspect_fit_fill_layout_core.sv -----
// Aspect fit/fill layout core: scale a source box toward a target, then anchor it.
// Products, decode, divider, output register; one request per cycle unless stalled.
// Depth is set by the restoring divider, one quotient bit per stage (16 stages).
// The whole pipeline advances whenever the output register is empty or taken.
// arst_n clears all valid bits and loads the register reset values.
// Depends on afl_pkg, afl_req_if, afl_rsp_if, afl_cfg_if.
module aspect_fit_fill_layout_core (
	input  logic clk,
	input  logic arst_n,
	afl_req_if.sink   req,
	afl_rsp_if.source rsp,
	afl_cfg_if.sink   cfg
);
	import afl_pkg::*;

	// configuration registers
	scale_mode_t scale_q;
	logic [3:0]  align_q;
	dim_t        tw_q, th_q, cw_q, ch_q;

	logic adv;

	// stage 1: products
	logic  v_s1;
	dim_t  sw_s1, sh_s1;
	prod_t pa_s1, pb_s1;

	// stage 2 decode result
	ctl_t  ctl_d;
	prod_t num_d;
	dim_t  den_d;
	logic  wide_d;

	// divider stages; index 0 is the stage-2 register
	div_t div_s  [0:DIV_STEPS];
	logic divv_s [0:DIV_STEPS];

	// output stage
	dim_t   quo_f, w_f, h_f;
	pos_t   px_f, py_f;

	assign cfg.ready = 1'b1;
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SM_FIT;
			align_q <= RST_ALIGN;
			tw_q    <= RST_TARGET_W;
			th_q    <= RST_TARGET_H;
			cw_q    <= RST_CONTAINER_W;
			ch_q    <= RST_CONTAINER_H;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SCALE_MODE:  scale_q <= scale_mode_t'(cfg.data[2:0]);
				REG_ALIGN_MODE:  align_q <= cfg.data[3:0];
				REG_TARGET_W:    tw_q <= cfg.data;
				REG_TARGET_H:    th_q <= cfg.data;
				REG_CONTAINER_W: cw_q <= cfg.data;
				REG_CONTAINER_H: ch_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// stage 1: cross products th*sw and sh*tw
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sw_s1 <= req.source_w;
			sh_s1 <= req.source_h;
			pa_s1 <= PROD_W'(th_q) * PROD_W'(req.source_w);
			pb_s1 <= PROD_W'(req.source_h) * PROD_W'(tw_q);
		end
	end

	// stage 2: choose axis; width axis divides sh*tw by sw, height axis sw*th by sh
	always_comb begin
		ctl_d.bad   = 1'b0;
		ctl_d.qsel  = QS_NONE;
		ctl_d.w_fix = '0;
		ctl_d.h_fix = '0;
		num_d       = pb_s1;
		den_d       = sw_s1;
		unique case (scale_q)
			SM_FIT, SM_FILL: begin
				if (sw_s1 == '0 || sh_s1 == '0) begin
					ctl_d.bad = 1'b1;
				end else if ((scale_q == SM_FIT) ? (pa_s1 > pb_s1) : (pa_s1 < pb_s1)) begin
					ctl_d.qsel  = QS_H;
					ctl_d.w_fix = tw_q;
				end else begin
					ctl_d.qsel  = QS_W;
					ctl_d.h_fix = th_q;
					num_d       = pa_s1;
					den_d       = sh_s1;
				end
			end
			SM_FILL_W: begin
				if (sw_s1 == '0) begin
					ctl_d.bad = 1'b1;
				end else begin
					ctl_d.qsel  = QS_H;
					ctl_d.w_fix = tw_q;
				end
			end
			SM_FILL_H: begin
				if (sh_s1 == '0) begin
					ctl_d.bad = 1'b1;
				end else begin
					ctl_d.qsel  = QS_W;
					ctl_d.h_fix = th_q;
					num_d       = pa_s1;
					den_d       = sh_s1;
				end
			end
			SM_STRETCH: begin
				ctl_d.w_fix = tw_q;
				ctl_d.h_fix = th_q;
			end
			SM_STRETCH_X: begin
				ctl_d.w_fix = tw_q;
				ctl_d.h_fix = sh_s1;
			end
			SM_STRETCH_Y: begin
				ctl_d.w_fix = sw_s1;
				ctl_d.h_fix = th_q;
			end
			SM_NONE: begin
				ctl_d.w_fix = sw_s1;
				ctl_d.h_fix = sh_s1;
			end
		endcase
		// quotient exceeds the dimension range iff the high half reaches the divisor
		wide_d = num_d[PROD_W-1:DIM_W] >= den_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divv_s[0] <= 1'b0;
		end else if (adv) begin
			divv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].ctl <= ctl_d;
			div_s[0].sat <= wide_d;
			div_s[0].den <= den_d;
			div_s[0].lo  <= num_d[DIM_W-1:0];
			div_s[0].q   <= '0;
			// start from zero when the quotient is not used, keeps rem < den
			div_s[0].rem <= (wide_d || ctl_d.qsel == QS_NONE) ? '0
				: num_d[PROD_W-1:DIM_W];
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [DIM_W:0] trial;
		logic           ge;

		assign trial = {div_s[k].rem, div_s[k].lo[DIM_W-1]};
		assign ge    = trial >= {1'b0, div_s[k].den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				divv_s[k+1] <= 1'b0;
			end else if (adv) begin
				divv_s[k+1] <= divv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k+1].ctl <= div_s[k].ctl;
				div_s[k+1].sat <= div_s[k].sat;
				div_s[k+1].den <= div_s[k].den;
				div_s[k+1].lo  <= {div_s[k].lo[DIM_W-2:0], 1'b0};
				div_s[k+1].q   <= {div_s[k].q[DIM_W-2:0], ge};
				div_s[k+1].rem <= ge ? DIM_W'(trial - {1'b0, div_s[k].den})
					: trial[DIM_W-1:0];
			end
		end
	end

	// offset along one axis; centre is floor((cont - size) / 2)
	function automatic pos_t place_axis(place_t where, dim_t cont, dim_t size);
		pos_t d;
		pos_t p;
		d = $signed({1'b0, cont}) - $signed({1'b0, size});
		unique case (where)
			PL_CENTER: p = d >>> 1;
			PL_END:    p = d;
			PL_START,
			PL_NONE:   p = '0;
		endcase
		return p;
	endfunction

	always_comb begin
		quo_f = div_s[DIV_STEPS].sat ? {DIM_W{1'b1}} : div_s[DIV_STEPS].q;
		w_f   = (div_s[DIV_STEPS].ctl.qsel == QS_W) ? quo_f : div_s[DIV_STEPS].ctl.w_fix;
		h_f   = (div_s[DIV_STEPS].ctl.qsel == QS_H) ? quo_f : div_s[DIV_STEPS].ctl.h_fix;
		px_f  = place_axis(align_col(align_q), cw_q, w_f);
		py_f  = place_axis(align_row(align_q), ch_q, h_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (adv) begin
			rsp.valid <= divv_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.out_w      <= w_f;
			rsp.out_h      <= h_f;
			rsp.pos_x      <= px_f;
			rsp.pos_y      <= py_f;
			rsp.bad_source <= div_s[DIV_STEPS].ctl.bad;
		end
	end

`ifndef SYNTHESIS
	a_bad_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.bad_source |-> rsp.out_w == '0 && rsp.out_h == '0)
		else $error("bad source result with nonzero size");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		divv_s[DIV_STEPS] && div_s[DIV_STEPS].den != '0
		|-> div_s[DIV_STEPS].rem < div_s[DIV_STEPS].den)
		else $error("divider remainder not below divisor");

	a_no_bad_undivided: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (scale_q == SM_STRETCH || scale_q == SM_STRETCH_X
		|| scale_q == SM_STRETCH_Y || scale_q == SM_NONE) |-> !rsp.bad_source)
		else $error("bad source flagged in a mode without division");

	a_stretch_target: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && scale_q == SM_STRETCH |-> rsp.out_w == tw_q && rsp.out_h == th_q)
		else $error("stretch result differs from target");
`endif

endmodule
